[hdl/lcc_pkg.sv]
package lcc_pkg;

   localparam int CARD_W        = 54;
   localparam int SUM_W         = 8;
   localparam int CNT_W         = 5;
   localparam int CLS_W         = 2;
   localparam int BCD_DIGITS    = 17;
   localparam int BCD_W         = 4 * BCD_DIGITS;
   localparam int BITS_PER_STEP = 3;
   localparam int DABBLE_STEPS  = CARD_W / BITS_PER_STEP;
   localparam int STEP_W        = 5;
   localparam int PC_W          = 2;

   typedef logic [1:0]      op_type;
   typedef logic [1:0]      cond_type;
   typedef logic [PC_W-1:0] pc_type;

   localparam op_type OP_LOAD   = 2'd0;
   localparam op_type OP_DABBLE = 2'd1;
   localparam op_type OP_DIGIT  = 2'd2;
   localparam op_type OP_FINISH = 2'd3;

   localparam cond_type C_ALWAYS      = 2'd0;
   localparam cond_type C_NO_START    = 2'd1;
   localparam cond_type C_MORE_BITS   = 2'd2;
   localparam cond_type C_MORE_DIGITS = 2'd3;

   localparam pc_type PC_IDLE   = 2'd0;
   localparam pc_type PC_DABBLE = 2'd1;
   localparam pc_type PC_DIGIT  = 2'd2;
   localparam pc_type PC_FINISH = 2'd3;

   localparam logic [CLS_W-1:0] CLS_INVALID   = 2'd0;
   localparam logic [CLS_W-1:0] CLS_PAIR_3437 = 2'd1;
   localparam logic [CLS_W-1:0] CLS_PAIR_5155 = 2'd2;
   localparam logic [CLS_W-1:0] CLS_LEAD_4    = 2'd3;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      pc_type   target;
   } uword_type;

   typedef struct packed {
      logic load;
      logic dabble;
      logic digit;
      logic finish;
   } ctrl_type;

   typedef struct packed {
      logic bits_last;
      logic digits_last;
   } stat_type;

   function automatic logic [63:0] pow10_64(input int e);
      logic [63:0] p;
      p = 64'd1;
      for (int i = 0; i < 19; i++) begin
         if (i < e) begin
            p = p * 64'd10;
         end
      end
      return p;
   endfunction

   function automatic logic [BCD_W-1:0] dabble_bit(input logic [BCD_W-1:0] b,
                                                    input logic serial_in);
      logic [BCD_W-1:0] r;
      r = b;
      for (int i = 0; i < BCD_DIGITS; i++) begin
         if (r[4*i +: 4] >= 4'd5) begin
            r[4*i +: 4] = r[4*i +: 4] + 4'd3;
         end
      end
      return {r[BCD_W-2:0], serial_in};
   endfunction

   function automatic logic [3:0] double_digit(input logic [3:0] d);
      logic [4:0] m;
      m = {d, 1'b0};
      if (d >= 4'd5) begin
         return 4'(m - 5'd9);
      end
      return 4'(m);
   endfunction

endpackage

[hdl/lcc_seq.sv]
module lcc_seq
   import lcc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  stat_type stat,
   output ctrl_type ctrl,
   output logic     busy
);

   localparam uword_type PROG [4] = '{
      '{op: OP_LOAD,   cond: C_NO_START,    target: PC_IDLE},
      '{op: OP_DABBLE, cond: C_MORE_BITS,   target: PC_DABBLE},
      '{op: OP_DIGIT,  cond: C_MORE_DIGITS, target: PC_DIGIT},
      '{op: OP_FINISH, cond: C_ALWAYS,      target: PC_IDLE}
   };

   pc_type    pc_ff, pc_in;
   uword_type uw;
   logic      jump;

   assign uw = PROG[pc_ff];

   always_comb begin
      unique case (uw.cond)
         C_ALWAYS:      jump = 1'b1;
         C_NO_START:    jump = !start;
         C_MORE_BITS:   jump = !stat.bits_last;
         C_MORE_DIGITS: jump = !stat.digits_last;
         default:       jump = 1'b1;
      endcase
      pc_in = jump ? uw.target : pc_type'(pc_ff + 1'b1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= PC_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   assign ctrl.load   = (uw.op == OP_LOAD) && start;
   assign ctrl.dabble = (uw.op == OP_DABBLE);
   assign ctrl.digit  = (uw.op == OP_DIGIT);
   assign ctrl.finish = (uw.op == OP_FINISH);
   assign busy        = (pc_ff != PC_IDLE);

endmodule

[hdl/lcc_dp.sv]
module lcc_dp
   import lcc_pkg::*;
#(
   parameter int MAX_DIGITS = 16
)
(
   input  logic              clock,
   input  logic              reset,
   input  ctrl_type          ctrl,
   input  logic [CARD_W-1:0] req_card_number,
   output stat_type          stat,
   output logic              rsp_valid,
   output logic [CLS_W-1:0]  rsp_issuer_class,
   output logic              rsp_luhn_ok,
   output logic [SUM_W-1:0]  rsp_luhn_sum,
   output logic [CNT_W-1:0]  rsp_digit_count
);

   localparam logic [63:0] LIMIT = pow10_64(MAX_DIGITS) - 64'd1;

   logic [CARD_W-1:0] shreg_ff, shreg_in;
   logic [BCD_W-1:0]  bcd_ff, bcd_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              reject_ff, reject_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [3:0]        prev_ff, prev_in;
   logic [3:0]        lead_hi_ff, lead_hi_in;
   logic [3:0]        lead_lo_ff, lead_lo_in;
   logic              valid_ff, valid_in;
   logic [CLS_W-1:0]  cls_ff, cls_in;
   logic              ok_ff, ok_in;
   logic [SUM_W-1:0]  osum_ff, osum_in;
   logic [CNT_W-1:0]  ocount_ff, ocount_in;

   logic [BCD_W-1:0]  b_tmp;
   logic [CARD_W-1:0] s_tmp;
   logic [3:0]        d;
   logic [3:0]        w;
   logic [15:0]       prod;
   logic [4:0]        q;
   logic [SUM_W-1:0]  q10;
   logic              ok;
   logic [CLS_W-1:0]  cls;

   assign stat.bits_last   = (step_ff == STEP_W'(DABBLE_STEPS - 1));
   assign stat.digits_last = (step_ff == STEP_W'(BCD_DIGITS - 1));

   always_comb begin
      shreg_in   = shreg_ff;
      bcd_in     = bcd_ff;
      step_in    = step_ff;
      reject_in  = reject_ff;
      sum_in     = sum_ff;
      count_in   = count_ff;
      prev_in    = prev_ff;
      lead_hi_in = lead_hi_ff;
      lead_lo_in = lead_lo_ff;
      valid_in   = 1'b0;
      cls_in     = cls_ff;
      ok_in      = ok_ff;
      osum_in    = osum_ff;
      ocount_in  = ocount_ff;

      b_tmp = bcd_ff;
      s_tmp = shreg_ff;
      for (int k = 0; k < BITS_PER_STEP; k++) begin
         b_tmp = dabble_bit(b_tmp, s_tmp[CARD_W-1]);
         s_tmp = {s_tmp[CARD_W-2:0], 1'b0};
      end

      d = bcd_ff[3:0];
      w = step_ff[0] ? double_digit(d) : d;

      prod = 16'(sum_ff) * 16'd205;
      q    = prod[15:11];
      q10  = SUM_W'({q, 3'b000}) + SUM_W'({q, 1'b0});
      ok   = (sum_ff == q10);

      cls = CLS_INVALID;
      if (ok) begin
         priority if (count_ff == CNT_W'(15) && lead_hi_ff == 4'd3
                      && (lead_lo_ff == 4'd4 || lead_lo_ff == 4'd7)) begin
            cls = CLS_PAIR_3437;
         end else if (count_ff == CNT_W'(16) && lead_hi_ff == 4'd5
                      && lead_lo_ff >= 4'd1 && lead_lo_ff <= 4'd5) begin
            cls = CLS_PAIR_5155;
         end else if ((count_ff == CNT_W'(13) || count_ff == CNT_W'(16))
                      && lead_hi_ff == 4'd4) begin
            cls = CLS_LEAD_4;
         end else begin
            cls = CLS_INVALID;
         end
      end

      if (ctrl.load) begin
         shreg_in   = req_card_number;
         bcd_in     = '0;
         step_in    = '0;
         reject_in  = {{(64-CARD_W){1'b0}}, req_card_number} > LIMIT;
         sum_in     = '0;
         count_in   = '0;
         prev_in    = '0;
         lead_hi_in = '0;
         lead_lo_in = '0;
      end

      if (ctrl.dabble) begin
         shreg_in = s_tmp;
         bcd_in   = b_tmp;
         step_in  = stat.bits_last ? '0 : STEP_W'(step_ff + 1'b1);
      end

      if (ctrl.digit) begin
         sum_in = SUM_W'(sum_ff + SUM_W'(w));
         if (d != 4'd0) begin
            count_in   = CNT_W'(step_ff + 1'b1);
            lead_hi_in = d;
            lead_lo_in = prev_ff;
         end
         prev_in = d;
         bcd_in  = {4'd0, bcd_ff[BCD_W-1:4]};
         step_in = STEP_W'(step_ff + 1'b1);
      end

      if (ctrl.finish) begin
         valid_in = 1'b1;
         if (reject_ff) begin
            cls_in    = CLS_INVALID;
            ok_in     = 1'b0;
            osum_in   = '0;
            ocount_in = '0;
         end else begin
            cls_in    = cls;
            ok_in     = ok;
            osum_in   = sum_ff;
            ocount_in = count_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      shreg_ff   <= shreg_in;
      bcd_ff     <= bcd_in;
      reject_ff  <= reject_in;
      sum_ff     <= sum_in;
      count_ff   <= count_in;
      prev_ff    <= prev_in;
      lead_hi_ff <= lead_hi_in;
      lead_lo_ff <= lead_lo_in;
      cls_ff     <= cls_in;
      ok_ff      <= ok_in;
      osum_ff    <= osum_in;
      ocount_ff  <= ocount_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_issuer_class = cls_ff;
   assign rsp_luhn_ok      = ok_ff;
   assign rsp_luhn_sum     = osum_ff;
   assign rsp_digit_count  = ocount_ff;

endmodule

[hdl/luhn_card_number_classifier.sv]
// The result word is strobed on rsp_valid, which is registered from the finish state.
// Start is taken only in idle, after the last word; binary goes to BCD at 3 bits per cycle,
// then the digits are walked one per cycle, and the finish state classifies the word.
// The receiver cannot stall; rsp_valid lasts one cycle and busy is low as it is shown.
// Reset (synchronous, active high) returns the sequencer to idle and drops rsp_valid.
module luhn_card_number_classifier
   import lcc_pkg::*;
#(
   parameter int MAX_DIGITS = 16
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [CARD_W-1:0] req_card_number,
   output logic              rsp_valid,
   output logic [CLS_W-1:0]  rsp_issuer_class,
   output logic              rsp_luhn_ok,
   output logic [SUM_W-1:0]  rsp_luhn_sum,
   output logic [CNT_W-1:0]  rsp_digit_count
);

   ctrl_type ctrl;
   stat_type stat;

   lcc_seq u_seq (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .ctrl  (ctrl),
      .busy  (busy)
   );

   lcc_dp #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (ctrl),
      .req_card_number  (req_card_number),
      .stat             (stat),
      .rsp_valid        (rsp_valid),
      .rsp_issuer_class (rsp_issuer_class),
      .rsp_luhn_ok      (rsp_luhn_ok),
      .rsp_luhn_sum     (rsp_luhn_sum),
      .rsp_digit_count  (rsp_digit_count)
   );

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted word did not raise busy");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobed while sequencer busy");

   a_class_needs_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_luhn_ok |-> rsp_issuer_class == CLS_INVALID)
      else $error("issuer class given on failed check");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_digit_count <= CNT_W'(MAX_DIGITS))
      else $error("digit count above limit");

endmodule
